@@ rtl/core/four_voice_wavetable_mixer_macros.svh @@
// Assertion macros for the mixer RTL, included by fvwm_ctrl.
// Each macro expects aclk and aresetn in scope.
`ifndef FOUR_VOICE_WAVETABLE_MIXER_MACROS_SVH
`define FOUR_VOICE_WAVETABLE_MIXER_MACROS_SVH

// same-cycle implication
`define FVWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fvwm check failed");

// next-cycle implication
`define FVWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fvwm check failed");

`endif

@@ rtl/core/fvwm_pkg.sv @@
// Shared constants, codes and control/status structs for the wavetable mixer.
// No dependencies.
package fvwm_pkg;

    localparam int VOICE_COUNT  = 4;
    localparam int WAVE_ENTRIES = 256;
    localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int WADDR_W      = VIDX_W + 8;
    localparam int WAVE_DEPTH   = VOICE_COUNT * WAVE_ENTRIES;

    localparam logic [15:0] SAMPLE_RATE_RESET = 16'd24585;
    localparam logic [14:0] REF_HZ            = 15'd22255;
    localparam logic [19:0] TONE_BASE         = 20'd783360;
    // x/60 as ((x>>2) * ceil(2^30/15)) >> 30, exact for 28-bit x
    localparam logic [26:0] LEN_RECIP         = 27'd71582789;

    // iterative divider geometry
    localparam int DIVIDEND_W = 52;
    localparam int DIVISOR_W  = 32;
    localparam int DCNT_W     = $clog2(DIVIDEND_W);

    localparam int S_TDATA_W = 96;

    localparam logic [1:0] CMD_RENDER = 2'd0;
    localparam logic [1:0] CMD_WAVE   = 2'd1;
    localparam logic [1:0] CMD_RATE   = 2'd2;
    localparam logic [1:0] CMD_TONE   = 2'd3;

    localparam logic [1:0] DK_VOICE = 2'd0;
    localparam logic [1:0] DK_TONE  = 2'd1;

    typedef struct packed {
        logic       load;
        logic       wave_wr;
        logic       div_start;
        logic [1:0] div_kind;
        logic       vstep_wr;
        logic       tstep_wr;
        logic       tlen_wr;
        logic       tone_stop;
        logic       acc_clear;
        logic       rd_issue;
        logic       acc_add;
        logic       out_load;
    } fvwm_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       skip;
        logic       div_done;
        logic       vidx_last;
    } fvwm_stat_t;

endpackage

@@ rtl/core/fvwm_div.sv @@
// Restoring divider, one quotient bit per cycle, fixed DIVIDEND_W steps.
// Depends on fvwm_pkg.
module fvwm_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [fvwm_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [fvwm_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [31:0]                     quotient
);
    import fvwm_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;

    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign rem_next = ge ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : DIVISOR_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[31:0];

endmodule

@@ rtl/core/fvwm_datapath.sv @@
// Mixer datapath: latched request, voice/tone state, wave memory, mix and saturate.
// Depends on fvwm_pkg and fvwm_div.
module fvwm_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fvwm_pkg::fvwm_cmd_t            cmd,
    output fvwm_pkg::fvwm_stat_t           stat,
    input  logic [fvwm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           cfg_valid,
    input  logic [15:0]                    cfg_data,
    output logic [7:0]                     m_tdata,
    output logic                           m_tuser
);
    import fvwm_pkg::*;

    // latched request
    logic [1:0]  cmd_reg;
    logic [1:0]  voice_reg;
    logic [7:0]  windex_reg;
    logic [7:0]  wvalue_reg;
    logic [31:0] rate_reg;
    logic [15:0] tdiv_reg;
    logic [7:0]  tamp_reg;
    logic [11:0] tticks_reg;
    logic        effv_reg;
    logic [7:0]  effs_reg;

    logic [15:0] sample_rate_reg;

    logic [31:0] vphase_reg [VOICE_COUNT];
    logic [31:0] vstep_reg  [VOICE_COUNT];
    logic [31:0] tphase_reg;
    logic [31:0] tstep_reg;
    logic [15:0] trem_reg;
    logic [7:0]  tlevel_reg;

    logic [VIDX_W-1:0] vidx_reg;
    logic signed [10:0] acc_reg;

    logic [7:0] wave_mem [WAVE_DEPTH];
    logic [7:0] rd_reg;

    logic [7:0] sample_reg;
    logic       tact_reg;

    // divider hookup
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [31:0]           div_q;

    logic              voice_ok;
    logic [VIDX_W-1:0] vsel;
    logic [31:0]       step_cur;
    logic              active;
    logic [31:0]       phase_new;

    always_comb begin
        case (cmd.div_kind)
            DK_VOICE: begin
                div_dividend = DIVIDEND_W'(47'(rate_reg) * 47'(REF_HZ));
                div_divisor  = 32'd1;
            end
            DK_TONE: begin
                div_dividend = {TONE_BASE, 32'd0};
                div_divisor  = 32'(tdiv_reg) * 32'(sample_rate_reg);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = 32'd1;
            end
        endcase
        if (cmd.div_kind == DK_VOICE) begin
            div_divisor = 32'(sample_rate_reg);
        end
    end

    fvwm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign voice_ok  = 32'(voice_reg) < 32'(VOICE_COUNT);
    assign vsel      = VIDX_W'(voice_reg);
    assign step_cur  = vstep_reg[vidx_reg];
    assign active    = step_cur != 32'd0;
    assign phase_new = vphase_reg[vidx_reg] + step_cur;

    assign stat.cmd       = cmd_reg;
    assign stat.skip      = (cmd_reg == CMD_RATE)
                          ? (rate_reg == 32'd0 || sample_rate_reg == 16'd0)
                          : (tdiv_reg == 16'd0 || sample_rate_reg == 16'd0);
    assign stat.div_done  = div_done;
    assign stat.vidx_last = vidx_reg == VIDX_W'(VOICE_COUNT - 1);

    // final mix terms
    logic signed [10:0] vsum;
    logic               tone_on;
    logic [31:0]        tphase_new;
    logic [8:0]         lvl_up;
    logic signed [11:0] tone_term;
    logic signed [11:0] eff_term;
    logic signed [11:0] total;
    logic [7:0]         sample_next;
    logic [15:0]        trem_next;
    logic [31:0]        len_clamped;

    // tone length: ticks * rate held in a register, /60 by reciprocal multiply
    logic [27:0]        len_prod_reg;
    logic [52:0]        len_mul;
    logic [22:0]        len_q;

    always_comb begin
        vsum       = acc_reg >>> 2;
        tone_on    = trem_reg != 16'd0;
        tphase_new = tphase_reg + tstep_reg;
        lvl_up     = 9'(tlevel_reg) + 9'd1;
        if (!tone_on) begin
            tone_term = '0;
        end else if (tphase_new[31]) begin
            tone_term = $signed({5'd0, tlevel_reg[7:1]});
        end else begin
            tone_term = $signed(12'd0 - {4'd0, lvl_up[8:1]});
        end
        eff_term  = effv_reg ? $signed({{4{effs_reg[7]}}, effs_reg}) : 12'sd0;
        total     = $signed({vsum[10], vsum}) + tone_term + eff_term;
        if (total > 12'sd127) begin
            sample_next = 8'h7f;
        end else if (total < -12'sd128) begin
            sample_next = 8'h80;
        end else begin
            sample_next = total[7:0];
        end
        trem_next   = tone_on ? trem_reg - 16'd1 : trem_reg;
        len_mul     = 53'(len_prod_reg[27:2]) * 53'(LEN_RECIP);
        len_q       = len_mul[52:30];
        len_clamped = (32'(len_q) > 32'(sample_rate_reg))
                    ? 32'(sample_rate_reg[15:2]) : 32'(len_q);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_tuser;
            voice_reg  <= s_tdata[1:0];
            windex_reg <= s_tdata[9:2];
            wvalue_reg <= s_tdata[17:10];
            rate_reg   <= s_tdata[49:18];
            tdiv_reg   <= s_tdata[65:50];
            tamp_reg   <= s_tdata[73:66];
            tticks_reg <= s_tdata[85:74];
            effv_reg   <= s_tdata[86];
            effs_reg   <= s_tdata[94:87];
        end
        len_prod_reg <= 28'(tticks_reg) * 28'(sample_rate_reg);
        if (cmd.out_load) begin
            sample_reg <= sample_next;
            tact_reg   <= trem_next != 16'd0;
        end
    end

    // wave table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wave_wr && voice_ok) begin
            wave_mem[{vsel, windex_reg}] <= wvalue_reg;
        end
        if (cmd.rd_issue) begin
            rd_reg <= wave_mem[{vidx_reg, phase_new[23:16]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= SAMPLE_RATE_RESET;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                vphase_reg[i] <= '0;
                vstep_reg[i]  <= '0;
            end
            tphase_reg <= '0;
            tstep_reg  <= '0;
            trem_reg   <= '0;
            tlevel_reg <= '0;
            vidx_reg   <= '0;
            acc_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                sample_rate_reg <= cfg_data;
            end
            if (cmd.vstep_wr && voice_ok) begin
                vstep_reg[vsel] <= stat.skip ? 32'd0 : div_q;
            end
            if (cmd.tstep_wr) begin
                tstep_reg  <= div_q;
                tlevel_reg <= tamp_reg;
            end
            if (cmd.tlen_wr) begin
                trem_reg <= len_clamped[15:0];
            end
            if (cmd.tone_stop) begin
                trem_reg <= '0;
            end
            if (cmd.acc_clear) begin
                vidx_reg <= '0;
                acc_reg  <= '0;
            end
            if (cmd.rd_issue && active) begin
                vphase_reg[vidx_reg] <= phase_new;
            end
            if (cmd.acc_add) begin
                vidx_reg <= vidx_reg + 1'b1;
                if (active) begin
                    acc_reg <= acc_reg + $signed({3'd0, rd_reg}) - 11'sd128;
                end
            end
            if (cmd.out_load) begin
                trem_reg <= trem_next;
                if (tone_on) begin
                    tphase_reg <= tphase_new;
                end
            end
        end
    end

    assign m_tdata = sample_reg;
    assign m_tuser = tact_reg;

endmodule

@@ rtl/core/fvwm_ctrl.sv @@
// Mixer sequencer: handshakes, request decode and step sequencing.
// Depends on fvwm_pkg and the assertion macro header.
module fvwm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  fvwm_pkg::fvwm_stat_t stat,
    output fvwm_pkg::fvwm_cmd_t  cmd
);
    import fvwm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       mvalid_reg;
    logic       mvalid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                case (stat.cmd)
                    CMD_RENDER: begin
                        cmd.acc_clear = 1'b1;
                        state_next    = S_RD;
                    end
                    CMD_WAVE: begin
                        cmd.wave_wr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    CMD_RATE: begin
                        if (stat.skip) begin
                            cmd.vstep_wr = 1'b1;
                            state_next   = S_IDLE;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_kind  = DK_VOICE;
                            state_next    = S_DIV;
                        end
                    end
                    CMD_TONE: begin
                        if (stat.skip) begin
                            cmd.tone_stop = 1'b1;
                            state_next    = S_IDLE;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_kind  = DK_TONE;
                            state_next    = S_DIV;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (stat.div_done) begin
                    if (stat.cmd == CMD_RATE) begin
                        cmd.vstep_wr = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        // step from the divider, length from the reciprocal multiply
                        cmd.tstep_wr = 1'b1;
                        cmd.tlen_wr  = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = stat.vidx_last ? S_OUT : S_RD;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

`include "four_voice_wavetable_mixer_macros.svh"

    `FVWM_ASSERT_NOW(a_done_when_waiting, stat.div_done, state_reg == S_DIV)
    `FVWM_ASSERT_NEXT(a_div_holds, state_reg == S_DIV && !stat.div_done, state_reg == S_DIV)
    `FVWM_ASSERT_NEXT(a_out_to_idle, cmd.out_load, state_reg == S_IDLE && mvalid_reg)
    `FVWM_ASSERT_NOW(a_no_result_overwrite, cmd.out_load && mvalid_reg, m_tready)

endmodule

@@ rtl/core/four_voice_wavetable_mixer.sv @@
// Top level of the four-voice wavetable mixer.
// Depends on fvwm_pkg, fvwm_ctrl, fvwm_datapath, fvwm_div.
//
// One request is handled at a time; the finished sample sits in an output
// register while the next request is taken. A render reads the wave
// memory once per voice through its registered read port and accumulates
// the active voices before loading the output register. A voice rate set
// and a tone set each run the one-bit-per-cycle 52-step divider (one
// division each; the tone length comes from a reciprocal multiply); a zero
// rate, divisor or sample rate skips the division. Config writes are
// always ready.
module four_voice_wavetable_mixer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // voice, wave_index, wave_value, voice_rate, tone_divisor, tone_amp,
    // tone_ticks, effect_valid, effect_sample, zero pad
    input  logic [fvwm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser, // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata, // sample_out
    output logic                           m_tuser, // tone_active
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [15:0]                    cfg_data
);
    import fvwm_pkg::*;

    fvwm_cmd_t  cmd;
    fvwm_stat_t stat;

    assign cfg_ready = 1'b1;

    fvwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fvwm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
